// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL modules; mntq_back uses them.
// Expects i_clk and i_rst_n in the scope of each use; SYNTH removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MNTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define MNTQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define MNTQ_ASSERT(lbl, prop, msg)
`define MNTQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/mntq_pkg.sv -----
// Shared types, codes and the all-notes-off byte function for the MIDI tx queue.
// No dependencies.
package mntq_pkg;

    localparam logic [2:0] FUNC_NOTE_ON  = 3'd0;
    localparam logic [2:0] FUNC_NOTE_OFF = 3'd1;
    localparam logic [2:0] FUNC_RAW      = 3'd2;
    localparam logic [2:0] FUNC_POLL     = 3'd3;
    localparam logic [2:0] FUNC_RESET    = 3'd4;

    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_CTRL     = 8'hb0;
    localparam logic [7:0] CTRL_SOUND_OFF  = 8'h78;
    localparam logic [7:0] CTRL_RESET_ALL  = 8'h79;
    localparam logic [7:0] DATA_MASK       = 8'h7f;

    localparam logic [2:0] SEQ_PH_STATUS_A = 3'd0;
    localparam logic [2:0] SEQ_PH_CTRL_A   = 3'd1;
    localparam logic [2:0] SEQ_PH_STATUS_B = 3'd3;
    localparam logic [2:0] SEQ_PH_CTRL_B   = 3'd4;
    localparam logic [2:0] SEQ_PH_LAST     = 3'd5;
    localparam logic [3:0] SEQ_CH_LAST     = 4'hf;

    localparam int QUEUE_LEVEL_W = 11;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_NOTE,
        OP_RAW,
        OP_POLL,
        OP_RESET
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       ready;
    } t_cmd;

    typedef struct packed {
        logic                     tx_valid;
        logic [7:0]               tx_byte;
        logic                     dropped;
        logic [QUEUE_LEVEL_W-1:0] queue_level;
        logic                     reset_busy;
    } t_result;

    function automatic logic [7:0] f_seq_byte(input logic [3:0] ch, input logic [2:0] phase);
        logic [7:0] b;
        case (phase) inside
            SEQ_PH_STATUS_A, SEQ_PH_STATUS_B: b = STATUS_CTRL | {4'h0, ch};
            SEQ_PH_CTRL_A:                    b = CTRL_SOUND_OFF;
            SEQ_PH_CTRL_B:                    b = CTRL_RESET_ALL;
            default:                          b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/mntq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mntq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- sv/mntq_fifo.sv -----
// Small register FIFO used for the command and result words.
// No dependencies.
module mntq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] P_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] C_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_count;
    logic             w_wr, w_rd;

    assign o_full    = (r_count == C_FULL);
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && !o_empty;
    assign o_rd_data = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == P_LAST) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == P_LAST) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_data[r_wp] <= i_wr_data;
        end
    end

endmodule

// ----- sv/mntq_front.sv -----
// Front end: decodes an input word into a command and queues it.
// Depends on mntq_pkg and mntq_fifo.
module mntq_front
    import mntq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_func,
    input  logic [3:0] i_channel,
    input  logic [7:0] i_key_number,
    input  logic [7:0] i_velocity,
    input  logic [7:0] i_data_byte,
    input  logic       i_tx_ready,
    input  logic       i_cmd_pop,
    output logic       o_cmd_empty,
    output t_cmd       o_cmd
);

    t_cmd                   w_cmd;
    logic [$bits(t_cmd)-1:0] w_rd_data;

    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = OP_NONE;
        w_cmd.ready = i_tx_ready;
        unique case (i_func) inside
            FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
                w_cmd.op = OP_NOTE;
                w_cmd.b0 = ((i_func == FUNC_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF)
                           | {4'h0, i_channel};
                w_cmd.b1 = i_key_number & DATA_MASK;
                w_cmd.b2 = i_velocity & DATA_MASK;
            end
            FUNC_RAW: begin
                w_cmd.op = OP_RAW;
                w_cmd.b0 = i_data_byte;
            end
            FUNC_POLL: begin
                w_cmd.op = OP_POLL;
            end
            FUNC_RESET: begin
                w_cmd.op = OP_RESET;
            end
            default: begin
                w_cmd.op = OP_NONE;
            end
        endcase
    end

    mntq_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_push),
        .i_wr_data (w_cmd),
        .o_full    (o_full),
        .i_rd_en   (i_cmd_pop),
        .o_rd_data (w_rd_data),
        .o_empty   (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(w_rd_data);

endmodule

// ----- sv/mntq_back.sv -----
// Back end: runs commands against the byte ring and the reset-all sequence.
// Depends on mntq_pkg, mntq_ram and assert_macros.svh.
`include "assert_macros.svh"
module mntq_back
    import mntq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int LW  = AW + 1;
    localparam int LVW = (LW > QUEUE_LEVEL_W) ? LW : QUEUE_LEVEL_W;
    localparam logic [AW-1:0] P_LAST   = AW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] L_DEPTH  = LW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] L_MAX_N3 = LW'(QUEUE_DEPTH - 4);
    localparam logic [LW-1:0] L_MAX_N1 = LW'(QUEUE_DEPTH - 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR1,
        S_WR2,
        S_RD
    } t_state;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] p);
        return (p == P_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [LW-1:0] f_level(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] rp);
        logic [LW-1:0] l;
        if (wp >= rp) begin
            l = {1'b0, wp} - {1'b0, rp};
        end else begin
            l = L_DEPTH - {1'b0, rp} + {1'b0, wp};
        end
        return l;
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [3:0]    r_seq_ch, n_seq_ch;
    logic [2:0]    r_seq_ph, n_seq_ph;
    logic          r_seq_act, n_seq_act;
    logic [7:0]    r_b1, n_b1, r_b2, n_b2;

    logic          w_we, w_re;
    logic [7:0]    w_wdata, w_rdata;
    logic [LW-1:0] w_lvl_now;
    logic [LVW-1:0] w_lvl_ext;

    assign w_lvl_now = f_level(r_wp, r_rp);

    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_seq_ch   = r_seq_ch;
        n_seq_ph   = r_seq_ph;
        n_seq_act  = r_seq_act;
        n_b1       = r_b1;
        n_b2       = r_b2;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_wdata    = i_cmd.b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_NOTE: begin
                            if (w_lvl_now <= L_MAX_N3) begin
                                w_we    = 1'b1;
                                n_wp    = f_adv(r_wp);
                                n_b1    = i_cmd.b1;
                                n_b2    = i_cmd.b2;
                                n_state = S_WR1;
                            end else begin
                                o_res_push    = 1'b1;
                                o_res.dropped = 1'b1;
                            end
                        end
                        OP_RAW: begin
                            o_res_push = 1'b1;
                            if (w_lvl_now <= L_MAX_N1) begin
                                w_we = 1'b1;
                                n_wp = f_adv(r_wp);
                            end else begin
                                o_res.dropped = 1'b1;
                            end
                        end
                        OP_POLL: begin
                            o_res_push = 1'b1;
                            if (i_cmd.ready && r_seq_act) begin
                                o_res.tx_valid = 1'b1;
                                o_res.tx_byte  = f_seq_byte(r_seq_ch, r_seq_ph);
                                if (r_seq_ph == SEQ_PH_LAST) begin
                                    n_seq_ph = '0;
                                    n_seq_ch = r_seq_ch + 4'd1;
                                    if (r_seq_ch == SEQ_CH_LAST) begin
                                        n_seq_act = 1'b0;
                                    end
                                end else begin
                                    n_seq_ph = r_seq_ph + 3'd1;
                                end
                            end else if (i_cmd.ready && (r_wp != r_rp)) begin
                                o_res_push = 1'b0;
                                w_re       = 1'b1;
                                n_rp       = f_adv(r_rp);
                                n_state    = S_RD;
                            end
                        end
                        OP_RESET: begin
                            o_res_push = 1'b1;
                            n_wp       = '0;
                            n_rp       = '0;
                            n_seq_ch   = '0;
                            n_seq_ph   = '0;
                            n_seq_act  = 1'b1;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_WR1: begin
                w_we    = 1'b1;
                w_wdata = r_b1;
                n_wp    = f_adv(r_wp);
                n_state = S_WR2;
            end
            S_WR2: begin
                w_we       = 1'b1;
                w_wdata    = r_b2;
                n_wp       = f_adv(r_wp);
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            S_RD: begin
                o_res_push     = 1'b1;
                o_res.tx_valid = 1'b1;
                o_res.tx_byte  = w_rdata;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_lvl_ext         = LVW'(f_level(n_wp, n_rp));
        o_res.queue_level = w_lvl_ext[QUEUE_LEVEL_W-1:0];
        o_res.reset_busy  = n_seq_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_seq_ch  <= '0;
            r_seq_ph  <= '0;
            r_seq_act <= 1'b0;
            r_b1      <= '0;
            r_b2      <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_seq_ch  <= n_seq_ch;
            r_seq_ph  <= n_seq_ph;
            r_seq_act <= n_seq_act;
            r_b1      <= n_b1;
            r_b2      <= n_b2;
        end
    end

    mntq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

    `MNTQ_ASSERT(a_res_room, o_res_push |-> !i_res_full, "result word pushed into full queue")
    `MNTQ_ASSERT(a_pop_idle, o_cmd_pop |-> (r_state == S_IDLE), "command taken while busy")
    `MNTQ_ASSERT(a_note_seq, (r_state == S_WR1) |=> (r_state == S_WR2), "note write broken")
    `MNTQ_ASSERT(a_ram_port, !(w_we && w_re), "ram read and write in one cycle")
    `MNTQ_ASSERT(a_seq_phase, r_seq_ph <= SEQ_PH_LAST, "sequence phase out of range")

endmodule

// ----- sv/midi_note_tx_queue_unit.sv -----
// MIDI transmit byte queue with all-notes-off sequence, top level.
// Depends on mntq_pkg, mntq_front, mntq_back, mntq_fifo.
//
// Input words enter on push/full; one result word per input comes out on
// empty/pop, in order. A note word queues three bytes, a raw word one byte,
// a poll hands out the next byte (sequence first, then queued bytes), and a
// reset-all word empties the ring and starts the 96-byte sequence.
// The back end takes a new word only in its idle state: a poll served from
// the ring passes through the read state S_RD (registered memory read), and
// a note word passes through the write states S_WR1 and S_WR2 (three byte
// writes into the single write port of the ring memory).
// A two-word command queue and a two-word result queue sit between the
// sides; when pop is held low the result queue fills, the back end waits,
// and full rises once the command queue is also full.
// Reset (i_rst_n low, synchronous) empties both queues and the ring and
// stops the sequence; the ring memory is not cleared and needs no sweep.
module midi_note_tx_queue_unit
    import mntq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [2:0]               i_func,
    input  logic [3:0]               i_channel,
    input  logic [7:0]               i_key_number,
    input  logic [7:0]               i_velocity,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_tx_ready,
    output logic                     empty,
    input  logic                     pop,
    output logic                     o_tx_valid,
    output logic [7:0]               o_tx_byte,
    output logic                     o_dropped,
    output logic [QUEUE_LEVEL_W-1:0] o_queue_level,
    output logic                     o_reset_busy
);

    t_cmd                       w_cmd;
    logic                       w_cmd_empty, w_cmd_pop;
    logic                       w_res_full, w_res_push;
    t_result                    w_res, w_res_out;
    logic [$bits(t_result)-1:0] w_res_bits;

    mntq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_channel    (i_channel),
        .i_key_number (i_key_number),
        .i_velocity   (i_velocity),
        .i_data_byte  (i_data_byte),
        .i_tx_ready   (i_tx_ready),
        .i_cmd_pop    (w_cmd_pop),
        .o_cmd_empty  (w_cmd_empty),
        .o_cmd        (w_cmd)
    );

    mntq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    mntq_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_res_push),
        .i_wr_data (w_res),
        .o_full    (w_res_full),
        .i_rd_en   (pop),
        .o_rd_data (w_res_bits),
        .o_empty   (empty)
    );

    assign w_res_out     = t_result'(w_res_bits);
    assign o_tx_valid    = w_res_out.tx_valid;
    assign o_tx_byte     = w_res_out.tx_byte;
    assign o_dropped     = w_res_out.dropped;
    assign o_queue_level = w_res_out.queue_level;
    assign o_reset_busy  = w_res_out.reset_busy;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for midi_note_tx_queue_unit: directed table, then random words.
// Expected results come from a byte-ring predictor kept inside this file.
// Depends on mntq_pkg and the unit's RTL.
module tb_top;
    import mntq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 2048;
    localparam int RING_MAX    = RING_DEPTH - 1;
    localparam int NOF_LEN     = 96;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CAP   = 350;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_LAST     = 3'd7;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] channel;
        logic [7:0] key;
        logic [7:0] vel;
        logic [7:0] data;
        logic       ready;
    } midi_word_t;

    typedef struct {
        midi_word_t w;
        bit         fixed;
        t_result    r;
    } stim_row_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic [2:0]               i_func;
    logic [3:0]               i_channel;
    logic [7:0]               i_key_number;
    logic [7:0]               i_velocity;
    logic [7:0]               i_data_byte;
    logic                     i_tx_ready;
    logic                     empty;
    logic                     pop;
    logic                     o_tx_valid;
    logic [7:0]               o_tx_byte;
    logic                     o_dropped;
    logic [QUEUE_LEVEL_W-1:0] o_queue_level;
    logic                     o_reset_busy;

    midi_note_tx_queue_unit #(.QUEUE_DEPTH(RING_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_channel     (i_channel),
        .i_key_number  (i_key_number),
        .i_velocity    (i_velocity),
        .i_data_byte   (i_data_byte),
        .i_tx_ready    (i_tx_ready),
        .empty         (empty),
        .pop           (pop),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_dropped     (o_dropped),
        .o_queue_level (o_queue_level),
        .o_reset_busy  (o_reset_busy)
    );

    // predictor state
    logic [7:0]  ring_mem [RING_DEPTH];
    logic [10:0] wr_ix;
    logic [10:0] rd_ix;
    logic [6:0]  nof_pos;
    bit          nof_active;

    t_result pending_midi_results[$];

    int  rd_wraps    = 0;
    int  drop_cnt    = 0;
    int  nof_bytes   = 0;
    int  sent_cnt    = 0;
    int  checked_cnt = 0;
    int  err_cnt     = 0;
    int  full_waits  = 0;
    int  wd_cycles   = 0;
    bit  calm        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [10:0] ring_fill();
        return wr_ix - rd_ix;
    endfunction

    function automatic logic [7:0] nof_byte(input logic [6:0] pos);
        logic [3:0] ch;
        logic [7:0] b;
        ch = 4'(pos / 6);
        case (3'(pos % 6))
            SEQ_PH_STATUS_A, SEQ_PH_STATUS_B: b = STATUS_CTRL | {4'h0, ch};
            SEQ_PH_CTRL_A:                    b = CTRL_SOUND_OFF;
            SEQ_PH_CTRL_B:                    b = CTRL_RESET_ALL;
            default:                          b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic t_result midi_tx_next(input midi_word_t w);
        t_result r;
        r = '0;
        case (w.func)
            FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
                if (RING_MAX - int'(ring_fill()) >= 3) begin
                    ring_mem[wr_ix] = ((w.func == FUNC_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF)
                                      | {4'h0, w.channel};
                    ring_mem[11'(wr_ix + 11'd1)] = w.key & DATA_MASK;
                    ring_mem[11'(wr_ix + 11'd2)] = w.vel & DATA_MASK;
                    wr_ix = wr_ix + 11'd3;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            FUNC_RAW: begin
                if (RING_MAX - int'(ring_fill()) >= 1) begin
                    ring_mem[wr_ix] = w.data;
                    wr_ix = wr_ix + 11'd1;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            FUNC_POLL: begin
                if (w.ready && nof_active) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = nof_byte(nof_pos);
                    nof_bytes++;
                    nof_pos = nof_pos + 7'd1;
                    if (nof_pos == 7'(NOF_LEN)) begin
                        nof_pos    = '0;
                        nof_active = 1'b0;
                    end
                end else if (w.ready && rd_ix != wr_ix) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = ring_mem[rd_ix];
                    rd_ix = rd_ix + 11'd1;
                    if (rd_ix == '0)
                        rd_wraps++;
                end
            end
            FUNC_RESET: begin
                wr_ix      = '0;
                rd_ix      = '0;
                nof_pos    = '0;
                nof_active = 1'b1;
            end
            default: ;
        endcase
        if (r.dropped)
            drop_cnt++;
        r.queue_level = ring_fill();
        r.reset_busy  = nof_active;
        return r;
    endfunction

    function automatic midi_word_t roll_word(input int pct_note, input int pct_raw,
                                             input int pct_poll, input int pct_reset);
        midi_word_t w;
        int pick;
        pick      = $urandom_range(0, 99);
        w.channel = 4'($urandom_range(0, 15));
        w.key     = 8'($urandom);
        w.vel     = 8'($urandom);
        w.data    = 8'($urandom);
        w.ready   = ($urandom_range(0, 9) != 0);
        if (pick < pct_note)
            w.func = ($urandom_range(0, 1) != 0) ? FUNC_NOTE_OFF : FUNC_NOTE_ON;
        else if (pick < pct_note + pct_raw)
            w.func = FUNC_RAW;
        else if (pick < pct_note + pct_raw + pct_poll)
            w.func = FUNC_POLL;
        else if (pick < pct_note + pct_raw + pct_poll + pct_reset)
            w.func = FUNC_RESET;
        else
            w.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_LAST));
        return w;
    endfunction

    function automatic stim_row_t drow(input logic [2:0] func, input logic [3:0] ch,
                                       input logic [7:0] key, input logic [7:0] vel,
                                       input logic [7:0] data, input bit rdy, input bit fixed,
                                       input bit v, input logic [7:0] b, input bit d,
                                       input int lvl, input bit busy);
        stim_row_t s;
        s.w             = '{func: func, channel: ch, key: key, vel: vel, data: data, ready: rdy};
        s.fixed         = fixed;
        s.r.tx_valid    = v;
        s.r.tx_byte     = b;
        s.r.dropped     = d;
        s.r.queue_level = QUEUE_LEVEL_W'(lvl);
        s.r.reset_busy  = busy;
        return s;
    endfunction

    // drive one word, wait for acceptance, then maybe pause
    task automatic offer_word(input midi_word_t w, input bit fixed, input t_result fixed_r);
        t_result r;
        push         <= 1'b1;
        i_func       <= w.func;
        i_channel    <= w.channel;
        i_key_number <= w.key;
        i_velocity   <= w.vel;
        i_data_byte  <= w.data;
        i_tx_ready   <= w.ready;
        @(posedge i_clk);
        while (full) begin
            full_waits++;
            @(posedge i_clk);
        end
        r = midi_tx_next(w);
        pending_midi_results.push_back(fixed ? fixed_r : r);
        sent_cnt++;
        if (!calm && (sent_cnt / 128) % 3 != 0 && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    initial begin : word_source
        stim_row_t dir_rows[$];
        int n;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_func       <= FUNC_NOTE_ON;
        i_channel    <= '0;
        i_key_number <= '0;
        i_velocity   <= '0;
        i_data_byte  <= '0;
        i_tx_ready   <= 1'b0;
        wr_ix      = '0;
        rd_ix      = '0;
        nof_pos    = '0;
        nof_active = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 0, 8'h00, 0, 0, 0),
            drow(FUNC_NOTE_ON,  4'hf, 8'hff, 8'hff, 8'h00, 0, 1, 0, 8'h00, 0, 3, 0),
            drow(FUNC_NOTE_OFF, 4'h0, 8'h00, 8'h00, 8'hff, 1, 1, 0, 8'h00, 0, 6, 0),
            drow(FUNC_RAW,      4'hf, 8'hff, 8'hff, 8'hff, 0, 1, 0, 8'h00, 0, 7, 0),
            drow(FUNC_RAW,      4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 0, 8'h00, 0, 8, 0),
            drow(FUNC_POLL,     4'hf, 8'hff, 8'hff, 8'hff, 0, 1, 0, 8'h00, 0, 8, 0),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'h9f, 0, 7, 0),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'h7f, 0, 6, 0),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'h7f, 0, 5, 0),
            drow(FUNC_POLL,     4'h3, 8'h12, 8'h34, 8'h56, 1, 0, 0, 8'h00, 0, 0, 0),
            drow(FUNC_POLL,     4'hc, 8'hab, 8'hcd, 8'hef, 1, 0, 0, 8'h00, 0, 0, 0),
            drow(FUNC_POLL,     4'h7, 8'h55, 8'haa, 8'h5a, 1, 0, 0, 8'h00, 0, 0, 0),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'hff, 0, 1, 0),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'h00, 0, 0, 0),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 0, 8'h00, 0, 0, 0),
            drow(FUNC_SPARE_LO, 4'hf, 8'hff, 8'hff, 8'hff, 1, 1, 0, 8'h00, 0, 0, 0),
            drow(FUNC_RAW,      4'h0, 8'h00, 8'h00, 8'h3c, 1, 1, 0, 8'h00, 0, 1, 0),
            drow(FUNC_RESET,    4'h9, 8'h11, 8'h22, 8'h33, 0, 1, 0, 8'h00, 0, 0, 1),
            drow(FUNC_RAW,      4'h0, 8'h00, 8'h00, 8'ha5, 1, 1, 0, 8'h00, 0, 1, 1),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'hb0, 0, 1, 1),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'h78, 0, 1, 1),
            drow(FUNC_RESET,    4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 0, 8'h00, 0, 0, 1),
            drow(FUNC_POLL,     4'h0, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'hb0, 0, 0, 1),
            drow(FUNC_LAST,     4'hf, 8'hff, 8'hff, 8'hff, 1, 1, 0, 8'h00, 0, 0, 1),
            drow(FUNC_NOTE_ON,  4'h5, 8'h80, 8'h81, 8'h00, 1, 0, 0, 8'h00, 0, 0, 0)
        };
        foreach (dir_rows[i])
            offer_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].r);

        // finish the all-notes-off run with pushes mixed in
        while (nof_active)
            offer_word(roll_word(10, 15, 75, 0), 1'b0, '0);

        repeat (200)
            offer_word(roll_word(25, 20, 50, 1), 1'b0, '0);

        // fill the ring to the brim, then push into a full ring
        while (RING_MAX - int'(ring_fill()) > 0)
            offer_word(roll_word(70, 30, 0, 0), 1'b0, '0);
        repeat (20)
            offer_word(roll_word(70, 30, 0, 0), 1'b0, '0);

        // drain part of the full ring
        n = 0;
        while (ring_fill() >= 11'd64 && n < DRAIN_CAP) begin
            offer_word(roll_word(3, 5, 92, 0), 1'b0, '0);
            n++;
        end

        calm = 1'b1;
        repeat (200)
            offer_word(roll_word(25, 20, 50, 1), 1'b0, '0);
        push <= 1'b0;

        while (pending_midi_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d words: %0d drops, %0d all-notes-off bytes, %0d ring read wraps.",
                 sent_cnt, drop_cnt, nof_bytes, rd_wraps);
        $display("Checked %0d results, input blocked by full for %0d cycles, %0d mismatches.",
                 checked_cnt, full_waits, err_cnt);
        if (err_cnt == 0)
            $display("PASS midi_note_tx_queue_unit");
        else
            $display("FAIL midi_note_tx_queue_unit");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        t_result got;
        t_result want;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!hold_done && checked_cnt >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!calm && (wd_cycles / 256) % 3 != 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                got.tx_valid    = o_tx_valid;
                got.tx_byte     = o_tx_byte;
                got.dropped     = o_dropped;
                got.queue_level = o_queue_level;
                got.reset_busy  = o_reset_busy;
                if (pending_midi_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected result word valid=%0b byte=%h drop=%0b lvl=%0d busy=%0b",
                                 got.tx_valid, got.tx_byte, got.dropped, got.queue_level,
                                 got.reset_busy);
                end else begin
                    want = pending_midi_results.pop_front();
                    checked_cnt++;
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"ERROR: word %0d exp valid=%0b byte=%h drop=%0b lvl=%0d ",
                                      "busy=%0b got valid=%0b byte=%h drop=%0b lvl=%0d busy=%0b"},
                                     checked_cnt, want.tx_valid, want.tx_byte, want.dropped,
                                     want.queue_level, want.reset_busy, got.tx_valid,
                                     got.tx_byte, got.dropped, got.queue_level, got.reset_busy);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        for (wd_cycles = 0; wd_cycles < CYCLE_LIMIT; wd_cycles++)
            @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results still pending.",
                 wd_cycles, pending_midi_results.size());
        $display("FAIL midi_note_tx_queue_unit");
        $finish;
    end

endmodule
